// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear-probe name/phone hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_FILLED  = 2'd1,
    MARK_DELETED = 2'd2,
    MARK_UNUSED  = 2'd3
  } mark_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_TOO_LONG  = 3'd6,
    ST_RSVD      = 3'd7
  } status_t;

  localparam int unsigned SumW = 14;

  // Finished-name command handed from the front to the back.
  typedef struct packed {
    func_t          func;
    logic           overflow;
    logic [SumW-1:0] sum;
    logic [31:0]    phone;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_HASH,
    BK_PROBE,
    BK_MARK,
    BK_CMP,
    BK_CMP_WAIT,
    BK_DECIDE,
    BK_COPY,
    BK_COPY_WAIT,
    BK_WRITE,
    BK_RESP,
    BK_CLEAR
  } bk_state_t;

endpackage

// ===== rtl/core/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/lpht_front.sv =====
// ----------------------------------------------------------------------------
// lpht_front
// Collects name characters into the key buffer and a running sum; on the last
// item pushes a command into a one-entry queue toward the back.
// ----------------------------------------------------------------------------
module lpht_front #(
  parameter int unsigned NameChars = 48,
  parameter int unsigned LenW      = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpht_pkg::func_t      func,
  input  logic [7:0]           key_char,
  input  logic                 key_last,
  input  logic [31:0]          phone_in,
  // key buffer write port
  output logic                 kb_we,
  output logic [LenW-1:0]      kb_waddr,
  output logic [7:0]           kb_wdata,
  // command to back
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output lpht_pkg::cmd_t       cmd,
  output logic [LenW-1:0]      cmd_len,
  input  logic                 back_busy
);
  import lpht_pkg::*;

  logic [LenW-1:0] key_length;
  logic [SumW-1:0] key_sum;
  logic            key_overflow;
  logic            held;
  logic            fire;
  logic            has_char;
  logic            room;

  // The key buffer is shared with the back, so wait while a command is open.
  assign in_ready = !held && !back_busy;
  assign fire     = in_valid && in_ready;
  assign has_char = key_char != 8'd0;
  assign room     = {1'b0, key_length} < (LenW+1)'(NameChars);

  assign kb_we    = fire && has_char && room;
  assign kb_waddr = key_length;
  assign kb_wdata = key_char;

  assign cmd_valid = held;

  // Accumulate the name; hold the finished command until the back takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= '0;
      key_sum      <= '0;
      key_overflow <= 1'b0;
      held         <= 1'b0;
    end else begin
      if (held && cmd_ready) held <= 1'b0;
      if (fire) begin
        if (key_last) begin
          key_length   <= '0;
          key_sum      <= '0;
          key_overflow <= 1'b0;
          held         <= 1'b1;
          cmd.func     <= func;
          cmd.phone    <= phone_in;
          cmd.overflow <= key_overflow || (has_char && !room);
          cmd.sum      <= (has_char && room) ? key_sum + SumW'(key_char) : key_sum;
          cmd_len      <= (has_char && room) ? key_length + LenW'(1) : key_length;
        end else if (has_char) begin
          if (room) begin
            key_length <= key_length + LenW'(1);
            key_sum    <= key_sum + SumW'(key_char);
          end else begin
            key_overflow <= 1'b1;
          end
        end
      end
    end
  end
endmodule

// ===== rtl/core/lpht_back.sv =====
// ----------------------------------------------------------------------------
// lpht_back
// Runs one table operation: walks the probe chain, compares stored names one
// character at a time, writes the entry and drives the result register.
// ----------------------------------------------------------------------------
module lpht_back #(
  parameter int unsigned TableSlots = 128,
  parameter int unsigned NameChars  = 48,
  parameter int unsigned LenW       = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  lpht_pkg::cmd_t                   cmd,
  input  logic [LenW-1:0]                  cmd_len,
  output logic                             busy,
  // key buffer read
  output logic [$clog2(NameChars)-1:0]     kb_raddr,
  input  logic [7:0]                       kb_rdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lpht_pkg::status_t                status,
  output logic [31:0]                      phone_out
);
  import lpht_pkg::*;

  localparam int unsigned SlotW  = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CharW  = $clog2(NameChars) > 0 ? $clog2(NameChars) : 1;
  localparam int unsigned NameD  = TableSlots * NameChars;
  localparam int unsigned NameW  = $clog2(NameD);
  localparam bit          Pow2   = (TableSlots & (TableSlots - 1)) == 0;
  // Largest shifted slot count that a hash sum can still exceed
  localparam int unsigned DivTop = Pow2 ? TableSlots
                                        : TableSlots << (SumW - $clog2(TableSlots));

  bk_state_t state, state_next;

  func_t            cur_func;
  logic [31:0]      cur_phone;
  logic [LenW-1:0]  len;
  logic [SlotW-1:0] idx;
  logic [SlotW-1:0] idx_inc;
  logic [SlotW:0]   probes;
  logic [SlotW-1:0] target;
  logic             have_target;
  logic             found;
  logic [LenW-1:0]  pos;
  logic [SlotW:0]   clr;
  logic [SumW-1:0]  rem, rem_next;
  logic [SumW-1:0]  dstep;

  // Memories
  logic             mark_we;
  logic [SlotW-1:0] mark_waddr;
  logic [1:0]       mark_wdata, mark_rdata;
  logic             len_we;
  logic [LenW-1:0]  len_rdata;
  logic             ph_we;
  logic [SlotW-1:0] ph_waddr;
  logic [31:0]      ph_rdata;
  logic             nm_we;
  logic [NameW-1:0] nm_waddr, nm_raddr;
  logic [7:0]       nm_rdata;

  lpht_ram #(.Width(2), .Depth(TableSlots)) u_mark (
    .clk, .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(idx), .rdata(mark_rdata));
  lpht_ram #(.Width(LenW), .Depth(TableSlots)) u_len (
    .clk, .we(len_we), .waddr(target), .wdata(len),
    .raddr(idx), .rdata(len_rdata));
  lpht_ram #(.Width(32), .Depth(TableSlots)) u_phone (
    .clk, .we(ph_we), .waddr(ph_waddr), .wdata(cur_phone),
    .raddr(idx), .rdata(ph_rdata));
  lpht_ram #(.Width(8), .Depth(NameD)) u_name (
    .clk, .we(nm_we), .waddr(nm_waddr), .wdata(kb_rdata),
    .raddr(nm_raddr), .rdata(nm_rdata));

  logic [NameW-1:0] base_idx, base_tgt;
  assign base_idx = NameW'(idx) * NameW'(NameChars);
  assign base_tgt = NameW'(target) * NameW'(NameChars);
  assign nm_raddr = base_idx + NameW'(pos);
  assign nm_waddr = base_tgt + NameW'(pos);
  assign kb_raddr = CharW'(pos);

  assign cmd_ready = (state == BK_IDLE) && !out_valid;
  assign busy      = (state != BK_IDLE) || cmd_valid;

  mark_t m;
  logic  last_probe, len_hit, char_hit, last_char;
  assign m          = mark_t'(mark_rdata);
  assign last_probe = probes == (SlotW+1)'(TableSlots - 1);
  assign len_hit    = len_rdata == len;
  assign char_hit   = nm_rdata == kb_rdata;
  assign last_char  = pos + LenW'(1) == len;
  assign idx_inc    = (idx == SlotW'(TableSlots - 1)) ? '0 : idx + SlotW'(1);
  // One restoring step of the hash reduction modulo the slot count
  assign rem_next   = (rem >= dstep) ? rem - dstep : rem;

  // Next state and memory strobes
  always_comb begin
    state_next = state;
    mark_we    = 1'b0;
    mark_waddr = idx;
    mark_wdata = MARK_FILLED;
    len_we     = 1'b0;
    ph_we      = 1'b0;
    ph_waddr   = idx;
    nm_we      = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr[SlotW-1:0];
        mark_wdata = MARK_EMPTY;
        if (clr == (SlotW+1)'(TableSlots - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          if (cmd.func == FUNC_NONE) state_next = BK_IDLE;
          else if (cmd.overflow) state_next = BK_RESP;
          else if (Pow2) state_next = BK_PROBE;
          else state_next = BK_HASH;
        end
      end
      BK_HASH: if (dstep == SumW'(TableSlots)) state_next = BK_PROBE;
      BK_PROBE: state_next = BK_MARK;
      BK_MARK: begin
        if (m == MARK_EMPTY) state_next = BK_DECIDE;
        else if (m == MARK_FILLED && len_hit) state_next = (len == '0) ? BK_DECIDE : BK_CMP;
        else if (last_probe) state_next = BK_DECIDE;
        else state_next = BK_PROBE;
      end
      BK_CMP: state_next = BK_CMP_WAIT;
      BK_CMP_WAIT: begin
        if (char_hit && last_char) state_next = BK_DECIDE;
        else if (char_hit) state_next = BK_CMP;
        else if (last_probe) state_next = BK_DECIDE;
        else state_next = BK_PROBE;
      end
      BK_DECIDE: begin
        state_next = BK_RESP;
        if (found) begin
          // update the phone in place or leave a tombstone
          if (cur_func == FUNC_ADD) ph_we = 1'b1;
          if (cur_func == FUNC_DELETE) begin
            mark_we    = 1'b1;
            mark_wdata = MARK_DELETED;
          end
        end else if (cur_func == FUNC_ADD && have_target) begin
          state_next = (len == '0) ? BK_WRITE : BK_COPY;
        end
      end
      BK_COPY: state_next = BK_COPY_WAIT;
      BK_COPY_WAIT: begin
        nm_we      = 1'b1;
        state_next = last_char ? BK_WRITE : BK_COPY;
      end
      BK_WRITE: begin
        mark_we    = 1'b1;
        mark_waddr = target;
        len_we     = 1'b1;
        ph_we      = 1'b1;
        ph_waddr   = target;
        state_next = BK_RESP;
      end
      BK_RESP: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_RESP) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        BK_CLEAR: clr <= clr + (SlotW+1)'(1);
        BK_IDLE: if (cmd_valid && cmd_ready) begin
          cur_func    <= cmd.func;
          cur_phone   <= cmd.phone;
          len         <= cmd_len;
          idx         <= cmd.sum[SlotW-1:0];
          rem         <= cmd.sum;
          dstep       <= SumW'(DivTop);
          probes      <= '0;
          have_target <= 1'b0;
          found       <= 1'b0;
          pos         <= '0;
          status      <= ST_TOO_LONG;
          phone_out   <= '0;
        end
        BK_HASH: begin
          rem   <= rem_next;
          dstep <= dstep >> 1;
          if (dstep == SumW'(TableSlots)) idx <= rem_next[SlotW-1:0];
        end
        BK_MARK: begin
          if (m != MARK_FILLED && !have_target) begin
            have_target <= 1'b1;
            target      <= idx;
          end
          if (m == MARK_FILLED && len_hit && len == '0) found <= 1'b1;
          // advance past a tombstone or a filled slot of another length
          if (m != MARK_EMPTY && !(m == MARK_FILLED && len_hit) && !last_probe) begin
            probes <= probes + (SlotW+1)'(1);
            idx    <= idx_inc;
          end
        end
        BK_CMP_WAIT: begin
          if (char_hit && last_char) found <= 1'b1;
          if (char_hit) begin
            pos <= pos + LenW'(1);
          end else begin
            pos <= '0;
            if (!last_probe) begin
              probes <= probes + (SlotW+1)'(1);
              idx    <= idx_inc;
            end
          end
        end
        BK_DECIDE: begin
          pos <= '0;
          if (found) begin
            unique case (cur_func)
              FUNC_ADD:    status <= ST_UPDATED;
              FUNC_SEARCH: begin status <= ST_FOUND; phone_out <= ph_rdata; end
              FUNC_DELETE: status <= ST_DELETED;
              default:     status <= ST_NOT_FOUND;
            endcase
          end else if (cur_func == FUNC_ADD) begin
            status <= have_target ? ST_INSERTED : ST_FULL;
          end else begin
            status <= ST_NOT_FOUND;
          end
        end
        BK_COPY_WAIT: pos <= pos + LenW'(1);
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Name-keyed linear-probing hash table holding one phone number per entry.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid/in_ready func key_char ...   | item in
//  out     | out_valid/out_ready status phone_out  | result out
//
//  Characters are taken one per cycle while no operation is open. A last item
//  runs one operation: it walks the probe slots, compares stored names one
//  character at a time and, on insert, copies the name into the name memory.
//  A slot count that is not a power of two adds hash reduction steps first.
//  Input stalls until the operation ends. After reset a pass over all
//  TABLE_SLOTS slot marks clears them before the first operation.
module linear_probe_hash_table_top #(
  parameter int unsigned TABLE_SLOTS = 128,
  parameter int unsigned NAME_CHARS  = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpht_pkg::func_t   func,
  input  logic [7:0]        key_char,
  input  logic              key_last,
  input  logic [31:0]       phone_in,
  output logic              out_valid,
  input  logic              out_ready,
  output lpht_pkg::status_t status,
  output logic [31:0]       phone_out
);
  import lpht_pkg::*;
  localparam int unsigned LenW  = $clog2(NAME_CHARS + 1);
  localparam int unsigned CharW = $clog2(NAME_CHARS) > 0 ? $clog2(NAME_CHARS) : 1;

  logic            kb_we, cmd_valid, cmd_ready, busy;
  logic [LenW-1:0] kb_waddr, cmd_len;
  logic [7:0]      kb_wdata, kb_rdata;
  logic [CharW-1:0] kb_raddr;
  cmd_t            cmd;

  lpht_front #(.NameChars(NAME_CHARS), .LenW(LenW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .key_char, .key_last, .phone_in,
    .kb_we, .kb_waddr, .kb_wdata, .cmd_valid, .cmd_ready, .cmd, .cmd_len,
    .back_busy(busy));

  lpht_ram #(.Width(8), .Depth(NAME_CHARS)) u_keybuf (
    .clk, .we(kb_we), .waddr(CharW'(kb_waddr)), .wdata(kb_wdata),
    .raddr(kb_raddr), .rdata(kb_rdata));

  lpht_back #(.TableSlots(TABLE_SLOTS), .NameChars(NAME_CHARS), .LenW(LenW)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .cmd_len, .busy, .kb_raddr, .kb_rdata,
    .out_valid, .out_ready, .status, .phone_out);
endmodule

// ===== rtl/core/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks for the hash table top level.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] phone_out
);
  import lpht_pkg::*;

  // Hold an offered result until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(phone_out))
    else $error("result dropped or changed while stalled");

  // Phone is zero unless found
  a_phone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> phone_out == 32'd0)
    else $error("phone_out nonzero without found");

  // Status code in range
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != ST_RSVD)
    else $error("reserved status");
endmodule

bind linear_probe_hash_table_top lpht_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .status, .phone_out);
